// ===== rtl/core/rfm_pkg.sv =====
// Package for the reciprocal frequency meter: field widths, register
// indexes, event codes and the status struct shared by the divider.
// No dependencies.
`timescale 1ns / 1ps

package rfm_pkg;

	localparam int STAMP_W  = 16;
	localparam int OVF_W    = 16;
	localparam int PERIOD_W = 32;
	localparam int SUM_W    = 39;
	localparam int GOOD_W   = 7;
	localparam int WAIT_W   = 17;
	localparam int NUMP_W   = 7;
	localparam int TMO_W    = 16;
	localparam int HZ_W     = 26;
	localparam int FREQ_W   = 42;
	localparam int FRAC_W   = 16;
	localparam int PROD_W   = GOOD_W + HZ_W;
	localparam int DVD_W    = PROD_W + FRAC_W;
	localparam int CNT_W    = $clog2(DVD_W + 1);
	localparam int CFG_W    = 26;
	localparam int CFG_IDX_W = 2;

	localparam logic [NUMP_W-1:0] MAX_PERIODS   = NUMP_W'(100);
	localparam logic [NUMP_W-1:0] RST_NUM_PER   = NUMP_W'(1);
	localparam logic [TMO_W-1:0]  RST_TIMEOUT   = TMO_W'(2000);
	localparam logic [HZ_W-1:0]   RST_CLOCK_HZ  = HZ_W'(16000000);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_PERIODS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ    = 2'd2;

	typedef enum logic [1:0] {
		FN_EDGE  = 2'd0,
		FN_OVF   = 2'd1,
		FN_TICK  = 2'd2,
		FN_START = 2'd3
	} func_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/rfm_chan_if.sv =====
// Handshake channels of the reciprocal frequency meter: the event input
// channel and the result output channel. Depends on rfm_pkg.
`timescale 1ns / 1ps

interface rfm_evt_if import rfm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	func_t                func;
	logic [STAMP_W-1:0]   cap_stamp;

	modport source (output valid, func, cap_stamp, input ready);
	modport sink   (input valid, func, cap_stamp, output ready);
endinterface

interface rfm_res_if import rfm_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [FREQ_W-1:0]    freq_q16;
	logic [GOOD_W-1:0]    good_periods;

	modport source (output valid, freq_q16, good_periods, input ready);
	modport sink   (input valid, freq_q16, good_periods, output ready);
endinterface

// ===== rtl/core/reciprocal_frequency_meter.sv =====
// Reciprocal frequency meter, top level. Depends on rfm_pkg, rfm_chan_if, rfm_div.
// Takes one event per cycle while the sequencer is in READY; a closing edge holds
// off further events while ACC folds in its period. An event that ends a measurement
// leads through MUL and LOAD to the divider (49 quotient bits); DIV waits for the
// quotient and a free output register. A zero reading skips the divider. Reset (arst_n,
// asynchronous, active low) clears all control state and loads the register defaults.
`timescale 1ns / 1ps

module reciprocal_frequency_meter import rfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	rfm_evt_if.sink               evt,
	rfm_res_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	// Control sequencer. READY takes events; ACC folds a finished period into
	// the running sum; MUL forms the good-period count times clock_hz; LOAD
	// starts the divider unless the reading is zero; DIV waits for the quotient
	// and for the output register to be free.
	typedef enum logic [4:0] {
		C_READY = 5'b00001,
		C_ACC   = 5'b00010,
		C_MUL   = 5'b00100,
		C_LOAD  = 5'b01000,
		C_DIV   = 5'b10000
	} ctl_t;

	// Measurement phase, as seen by the edge and tick events.
	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_FIRST  = 3'b010,
		PH_SECOND = 3'b100
	} phase_t;

	ctl_t               ctl_q;
	phase_t             phase_q;

	// Configuration registers.
	logic [NUMP_W-1:0]  num_periods_q;
	logic [TMO_W-1:0]   timeout_ms_q;
	logic [HZ_W-1:0]    clock_hz_q;

	// Measurement state.
	logic [OVF_W-1:0]   ovf_cnt_q;
	logic [STAMP_W-1:0] first_stamp_q;
	logic [OVF_W-1:0]   first_ovf_q;
	logic [WAIT_W-1:0]  wait_q;
	logic [NUMP_W-1:0]  attempts_q;
	logic [GOOD_W-1:0]  good_q;
	logic [SUM_W-1:0]   sum_q;
	logic [PERIOD_W-1:0] period_s1;
	logic [PROD_W-1:0]  prod_q;
	logic               zero_q;

	// Output register.
	logic               res_valid_q;
	logic [FREQ_W-1:0]  freq_q;
	logic [GOOD_W-1:0]  good_out_q;

	// Divider hookup.
	logic               div_start;
	div_stat_t          div_stat;
	logic [DVD_W-1:0]   div_quot;

	logic               accept;
	logic [NUMP_W-1:0]  n_clamped;
	logic [WAIT_W-1:0]  wait_inc;
	logic               timed_out;
	logic [NUMP_W-1:0]  attempts_next;
	logic               last_attempt;
	logic [PERIOD_W-1:0] period_new;
	logic               slot_free;
	logic               result_ready;

	assign evt.ready = (ctl_q == C_READY);
	assign accept    = evt.valid && evt.ready;

	// Attempts per measurement: zero counts as one, large values are capped.
	always_comb begin
		n_clamped = num_periods_q;
		if (num_periods_q == '0) begin
			n_clamped = NUMP_W'(1);
		end else if (num_periods_q > MAX_PERIODS) begin
			n_clamped = MAX_PERIODS;
		end
	end

	// The elapsed-wait counter saturates instead of wrapping.
	assign wait_inc  = (wait_q == '1) ? wait_q : wait_q + WAIT_W'(1);
	assign timed_out = wait_inc > {1'b0, timeout_ms_q};

	// Ending an attempt always consumes one attempt; the last one emits.
	assign attempts_next = (attempts_q != '0) ? attempts_q - NUMP_W'(1) : attempts_q;
	assign last_attempt  = (attempts_next == '0);

	// Period in timer counts: whole overflows above the stamp difference,
	// all taken modulo 2^32. A negative stamp difference borrows from the
	// overflow part, exactly as two's complement arithmetic gives it.
	assign period_new = {ovf_cnt_q - first_ovf_q, {STAMP_W{1'b0}}}
		+ {{(PERIOD_W-STAMP_W){1'b0}}, evt.cap_stamp}
		- {{(PERIOD_W-STAMP_W){1'b0}}, first_stamp_q};

	assign slot_free    = !res_valid_q || res.ready;
	assign result_ready = zero_q || div_stat.done;
	assign div_start    = (ctl_q == C_LOAD) && !zero_q;

	// Configuration writes; indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_periods_q <= RST_NUM_PER;
			timeout_ms_q  <= RST_TIMEOUT;
			clock_hz_q    <= RST_CLOCK_HZ;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_PERIODS: num_periods_q <= cfg_data[NUMP_W-1:0];
				REG_TIMEOUT_MS:  timeout_ms_q  <= cfg_data[TMO_W-1:0];
				REG_CLOCK_HZ:    clock_hz_q    <= cfg_data[HZ_W-1:0];
				default: ;
			endcase
		end
	end

	// Event handling and the control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q         <= C_READY;
			phase_q       <= PH_IDLE;
			ovf_cnt_q     <= '0;
			first_stamp_q <= '0;
			first_ovf_q   <= '0;
			wait_q        <= '0;
			attempts_q    <= '0;
			good_q        <= '0;
			sum_q         <= '0;
		end else begin
			case (ctl_q)
				C_READY: begin
					if (accept) begin
						case (evt.func)
							FN_OVF: begin
								ovf_cnt_q <= ovf_cnt_q + OVF_W'(1);
							end
							FN_START: begin
								// A start also abandons any measurement in progress.
								attempts_q <= n_clamped;
								good_q     <= '0;
								sum_q      <= '0;
								wait_q     <= '0;
								phase_q    <= PH_FIRST;
							end
							FN_TICK: begin
								if (phase_q != PH_IDLE) begin
									if (timed_out) begin
										attempts_q <= attempts_next;
										wait_q     <= '0;
										phase_q    <= last_attempt ? PH_IDLE : PH_FIRST;
										if (last_attempt) begin
											ctl_q <= C_MUL;
										end
									end else begin
										wait_q <= wait_inc;
									end
								end
							end
							FN_EDGE: begin
								if (phase_q == PH_FIRST) begin
									first_stamp_q <= evt.cap_stamp;
									first_ovf_q   <= ovf_cnt_q;
									wait_q        <= '0;
									phase_q       <= PH_SECOND;
								end else if (phase_q == PH_SECOND) begin
									ctl_q <= C_ACC;
								end
							end
							default: ;
						endcase
					end
				end
				C_ACC: begin
					// A zero period is not counted as a good one.
					if (period_s1 != '0) begin
						sum_q  <= sum_q + {{(SUM_W-PERIOD_W){1'b0}}, period_s1};
						good_q <= good_q + GOOD_W'(1);
					end
					attempts_q <= attempts_next;
					wait_q     <= '0;
					phase_q    <= last_attempt ? PH_IDLE : PH_FIRST;
					ctl_q      <= last_attempt ? C_MUL : C_READY;
				end
				C_MUL: begin
					ctl_q <= C_LOAD;
				end
				C_LOAD: begin
					ctl_q <= C_DIV;
				end
				C_DIV: begin
					if (result_ready && slot_free) begin
						ctl_q <= C_READY;
					end
				end
				default: begin
					ctl_q <= C_READY;
				end
			endcase
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (accept && evt.func == FN_EDGE && phase_q == PH_SECOND) begin
			period_s1 <= period_new;
		end
		if (ctl_q == C_MUL) begin
			prod_q <= PROD_W'(good_q) * PROD_W'(clock_hz_q);
			zero_q <= (good_q == '0) || (sum_q == '0) || (clock_hz_q == '0);
		end
	end

	// Output register: holds a result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl_q == C_DIV && result_ready && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_q == C_DIV && result_ready && slot_free) begin
			freq_q     <= zero_q ? '0 : div_quot[FREQ_W-1:0];
			good_out_q <= good_q;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.freq_q16     = freq_q;
	assign res.good_periods = good_out_q;

	// The dividend is the product scaled by 2^16 for the Q.16 result.
	rfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({prod_q, {FRAC_W{1'b0}}}),
		.divisor  (sum_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

endmodule

// ===== rtl/core/rfm_div.sv =====
// Restoring divider for the meter: one quotient bit per cycle.
// Depends on rfm_pkg.
`timescale 1ns / 1ps

module rfm_div import rfm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DVD_W-1:0]   dividend,
	input  logic [SUM_W-1:0]   divisor,
	output div_stat_t          stat,
	output logic [DVD_W-1:0]   quotient
);

	logic [DVD_W-1:0] dvd_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic             msb;
	logic [SUM_W+1:0] diff;
	logic             fits;
	logic [SUM_W-1:0] rem_next;

	// The partial remainder stays below the divisor, so after a successful
	// subtract it fits back into SUM_W bits.
	assign msb      = dvd_q[DVD_W-1];
	assign diff     = {1'b0, rem_q, msb} - {2'b00, dsr_q};
	assign fits     = !diff[SUM_W+1];
	assign rem_next = fits ? diff[SUM_W-1:0] : {rem_q[SUM_W-2:0], msb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

// ===== rtl/core/rfm_checker.sv =====
// Port-level checks for the reciprocal frequency meter, bound to the top.
// Depends on rfm_pkg and reciprocal_frequency_meter.
`timescale 1ns / 1ps

module rfm_checker import rfm_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [FREQ_W-1:0]  res_freq,
	input logic [GOOD_W-1:0]  res_good
);

	// A waiting result holds its value until taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_freq) && $stable(res_good))
		else $error("result changed while stalled");

	// No more good periods than the attempt cap allows.
	a_good_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_good <= MAX_PERIODS)
		else $error("good period count above cap");

	// Without a good period the frequency reads zero.
	a_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_good == '0 |-> res_freq == '0)
		else $error("nonzero frequency without good periods");

	// Nothing is offered in the first cycle after reset.
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !res_valid)
		else $error("result offered right after reset");

endmodule

bind reciprocal_frequency_meter rfm_checker u_rfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_freq  (res.freq_q16),
	.res_good  (res.good_periods)
);

// ===== test/testbench.sv =====
// Self-checking testbench for reciprocal_frequency_meter: drives timer events and
// register writes, predicts every frequency reading and checks it on the result channel.
// Depends on rfm_pkg, rfm_chan_if and the reciprocal_frequency_meter RTL.
`timescale 1ns / 1ps

module testbench;
	import rfm_pkg::*;

	// Cycles with no transfer and no register write before the run is declared hung.
	// The slowest legitimate quiet stretch is the final division plus a receiver
	// stall, or the SETTLE_CYCLES pause between phases.
	localparam int WATCHDOG_LIMIT = 3000;
	// Pause after the last reading of a phase before the registers are touched again.
	localparam int SETTLE_CYCLES  = 60;
	// Rough count of random events after the directed part.
	localparam int RANDOM_EVENTS  = 750;

	typedef struct {
		func_t              func;
		logic [STAMP_W-1:0] stamp;
	} timer_evt_t;

	typedef struct {
		logic [FREQ_W-1:0]  freq;
		logic [GOOD_W-1:0]  good;
	} reading_t;

	typedef enum logic [1:0] {
		MTR_IDLE,
		MTR_FIRST,
		MTR_SECOND
	} mtr_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	rfm_evt_if evt ();
	rfm_res_if res ();

	// Local copies of everything the testbench drives, so that every input of the
	// block holds a known value from time zero.
	logic               evt_valid = 1'b0;
	func_t              evt_func = FN_EDGE;
	logic [STAMP_W-1:0] evt_stamp = '0;
	logic               res_ready = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;

	assign evt.valid     = evt_valid;
	assign evt.func      = evt_func;
	assign evt.cap_stamp = evt_stamp;
	assign res.ready     = res_ready;

	reciprocal_frequency_meter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt       (evt.sink),
		.res       (res.source),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Register shadows, loaded with the reset values of the block.
	logic [NUMP_W-1:0]  mtr_nper_cfg = RST_NUM_PER;
	logic [TMO_W-1:0]   mtr_tmo_cfg = RST_TIMEOUT;
	logic [HZ_W-1:0]    mtr_hz_cfg = RST_CLOCK_HZ;

	// Predicted measurement state.
	mtr_phase_t         mtr_phase = MTR_IDLE;
	logic [OVF_W-1:0]   mtr_ovf = '0;
	logic [STAMP_W-1:0] mtr_first_stamp = '0;
	logic [OVF_W-1:0]   mtr_first_ovf = '0;
	logic [WAIT_W-1:0]  mtr_wait_ms = '0;
	logic [GOOD_W-1:0]  mtr_left = '0;
	logic [GOOD_W-1:0]  mtr_good = '0;
	logic [SUM_W-1:0]   mtr_sum = '0;

	timer_evt_t evt_backlog[$];
	timer_evt_t evt_next;
	reading_t   pending_readings[$];

	int  evt_total = 0;
	int  evt_done = 0;
	int  evt_gap = 0;
	int  res_stall = 0;
	int  res_draw = 0;
	int  idle_cycles = 0;
	int  err_cnt = 0;
	bit  evt_idle_on = 1'b0;
	bit  res_idle_on = 1'b0;

	// An attempt has ended, by its closing edge or by a timeout. When it was the
	// last one, the reading is formed from the good periods gathered so far:
	// the good-period count times clock_hz in Q.16, divided by the period sum.
	task automatic close_attempt();
		logic [48:0] dividend;
		logic [48:0] quotient;
		reading_t    rd;
		if (mtr_left != 0)
			mtr_left = mtr_left - 1'b1;
		mtr_wait_ms = '0;
		if (mtr_left != 0) begin
			mtr_phase = MTR_FIRST;
		end else begin
			mtr_phase = MTR_IDLE;
			quotient = '0;
			if (mtr_good != 0 && mtr_sum != 0) begin
				dividend = (49'(mtr_good) * 49'(mtr_hz_cfg)) << FRAC_W;
				quotient = dividend / 49'(mtr_sum);
			end
			rd.freq = quotient[FREQ_W-1:0];
			rd.good = mtr_good;
			pending_readings.push_back(rd);
		end
	endtask

	// Advances the predicted state by one accepted event.
	task automatic meter_apply_event(input func_t fn, input logic [STAMP_W-1:0] stamp);
		logic [OVF_W-1:0]    ovf_diff;
		logic [PERIOD_W-1:0] period;
		logic [NUMP_W-1:0]   attempts;
		case (fn)
		FN_OVF: begin
			mtr_ovf = mtr_ovf + 1'b1;
		end
		FN_START: begin
			// A start always begins a fresh measurement, even in the middle of one.
			attempts = mtr_nper_cfg;
			if (attempts == 0)
				attempts = 1;
			if (attempts > MAX_PERIODS)
				attempts = MAX_PERIODS;
			mtr_left = attempts;
			mtr_good = '0;
			mtr_sum = '0;
			mtr_wait_ms = '0;
			mtr_phase = MTR_FIRST;
		end
		FN_TICK: begin
			if (mtr_phase != MTR_IDLE) begin
				if (mtr_wait_ms != '1)
					mtr_wait_ms = mtr_wait_ms + 1'b1;
				if (mtr_wait_ms > WAIT_W'(mtr_tmo_cfg))
					close_attempt();
			end
		end
		default: begin
			if (mtr_phase == MTR_FIRST) begin
				mtr_first_stamp = stamp;
				mtr_first_ovf = mtr_ovf;
				mtr_wait_ms = '0;
				mtr_phase = MTR_SECOND;
			end else if (mtr_phase == MTR_SECOND) begin
				// Whole overflows in the upper half, the stamp difference wraps into it.
				ovf_diff = mtr_ovf - mtr_first_ovf;
				period = {ovf_diff, 16'h0000} + (PERIOD_W'(stamp) - PERIOD_W'(mtr_first_stamp));
				if (period != 0) begin
					mtr_sum = mtr_sum + SUM_W'(period);
					mtr_good = mtr_good + 1'b1;
				end
				close_attempt();
			end
		end
		endcase
	endtask

	// Event driver. Each event is followed by a random number of empty cycles
	// when idling is on for the current phase; valid never drops while an event
	// waits for ready.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid <= 1'b0;
			evt_gap <= 0;
		end else begin
			if (evt_valid && evt.ready) begin
				meter_apply_event(evt_func, evt_stamp);
				evt_done++;
			end
			if (evt_valid && !evt.ready) begin
				// Hold the current event until the block takes it.
			end else if (evt_gap != 0) begin
				evt_valid <= 1'b0;
				evt_gap <= evt_gap - 1;
			end else if (evt_backlog.size() != 0) begin
				evt_next = evt_backlog.pop_front();
				evt_valid <= 1'b1;
				evt_func <= evt_next.func;
				evt_stamp <= evt_next.stamp;
				evt_gap <= evt_idle_on ? $urandom_range(0, 8) : 0;
			end else begin
				evt_valid <= 1'b0;
			end
		end
	end

	// Result monitor. Compares each transfer with the oldest predicted reading;
	// after each transfer ready is withheld for a random number of cycles when idling is on.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			res_stall <= 0;
		end else begin
			if (res.valid && res_ready) begin
				if (pending_readings.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected reading: freq_q16 %0d good_periods %0d",
							res.freq_q16, res.good_periods);
				end else begin
					if (pending_readings[0].freq !== res.freq_q16 ||
							pending_readings[0].good !== res.good_periods) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("mismatch: freq_q16 %0d exp %0d, good %0d exp %0d",
								res.freq_q16, pending_readings[0].freq,
								res.good_periods, pending_readings[0].good);
					end
					void'(pending_readings.pop_front());
				end
				res_draw = res_idle_on ? $urandom_range(0, 8) : 0;
				res_ready <= (res_draw == 0);
				res_stall <= res_draw;
			end else if (!res_ready) begin
				if (res_stall > 1) begin
					res_stall <= res_stall - 1;
				end else begin
					res_ready <= 1'b1;
					res_stall <= 0;
				end
			end
		end
	end

	// Watchdog: any transfer or register write restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (evt_valid && evt.ready) || (res.valid && res_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_evt(input func_t fn, input logic [STAMP_W-1:0] stamp);
		timer_evt_t e;
		e.func = fn;
		e.stamp = stamp;
		evt_backlog.push_back(e);
		evt_total++;
	endtask

	// A register write pulses cfg_we; the shadow is updated at the same time,
	// which is safe because writes only happen while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		REG_NUM_PERIODS: mtr_nper_cfg = val[NUMP_W-1:0];
		REG_TIMEOUT_MS:  mtr_tmo_cfg = val[TMO_W-1:0];
		default:         mtr_hz_cfg = val[HZ_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [NUMP_W-1:0] nper, input logic [TMO_W-1:0] tmo,
			input logic [HZ_W-1:0] hz);
		write_reg(REG_NUM_PERIODS, CFG_W'(nper));
		write_reg(REG_TIMEOUT_MS, CFG_W'(tmo));
		write_reg(REG_CLOCK_HZ, CFG_W'(hz));
	endtask

	// Waits until every event has been taken and every reading has come back,
	// then lets the divider and any other leftover work drain.
	task automatic settle();
		do
			@(negedge clk);
		while (evt_done != evt_total || pending_readings.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One well-formed attempt with random content: ticks and an edge, then ticks, up to two
	// overflows and a final edge; about one in ten instead repeats the edge for a zero period.
	task automatic push_attempt(input int tick_max);
		logic [STAMP_W-1:0] lead_stamp;
		lead_stamp = STAMP_W'($urandom);
		repeat ($urandom_range(0, tick_max)) push_evt(FN_TICK, STAMP_W'($urandom));
		push_evt(FN_EDGE, lead_stamp);
		if ($urandom_range(0, 9) == 0) begin
			push_evt(FN_EDGE, lead_stamp);
		end else begin
			repeat ($urandom_range(0, tick_max)) push_evt(FN_TICK, STAMP_W'($urandom));
			repeat ($urandom_range(0, 2)) push_evt(FN_OVF, STAMP_W'($urandom));
			push_evt(FN_EDGE, STAMP_W'($urandom));
		end
	endtask

	// A start and the attempts it calls for, with the odd stray event mixed in;
	// a stray start restarts the measurement in progress.
	task automatic push_measurement(input int attempts, input int tick_max);
		push_evt(FN_START, STAMP_W'($urandom));
		repeat (attempts) begin
			if ($urandom_range(0, 9) == 0)
				push_evt(func_t'($urandom_range(0, 3)), STAMP_W'($urandom));
			push_attempt(tick_max);
		end
	endtask

	initial begin
		int                 rand_base;
		int                 attempts;
		int                 tick_max;
		logic [NUMP_W-1:0]  nper;
		logic [TMO_W-1:0]   tmo;
		logic [HZ_W-1:0]    hz;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: one attempt, 2000 ms timeout, 16 MHz timer.
		// Edges and ticks while idle are ignored; overflows are always counted.
		push_evt(FN_EDGE, 16'hA5A5);
		push_evt(FN_TICK, 16'h5A5A);
		push_evt(FN_OVF, 16'h0000);
		// Largest period without an overflow.
		push_evt(FN_START, 16'h0000);
		push_evt(FN_EDGE, 16'h0000);
		push_evt(FN_EDGE, 16'hFFFF);
		// Shortest period, across a timer overflow.
		push_evt(FN_START, 16'hFFFF);
		push_evt(FN_EDGE, 16'hFFFF);
		push_evt(FN_OVF, 16'hFFFF);
		push_evt(FN_EDGE, 16'h0000);
		// Zero period: the attempt is skipped and the reading is zero.
		push_evt(FN_START, 16'h0000);
		push_evt(FN_EDGE, 16'h1234);
		push_evt(FN_EDGE, 16'h1234);
		// Start in the middle of a measurement, then a period over two overflows.
		push_evt(FN_START, 16'h0000);
		push_evt(FN_EDGE, 16'h8000);
		push_evt(FN_START, 16'h0000);
		push_evt(FN_EDGE, 16'h0001);
		push_evt(FN_OVF, 16'h0000);
		push_evt(FN_OVF, 16'h0000);
		push_evt(FN_TICK, 16'h0000);
		push_evt(FN_EDGE, 16'h0000);
		// Later stamp below the first one with no overflow: the period wraps.
		push_evt(FN_START, 16'h0000);
		push_evt(FN_EDGE, 16'h1234);
		push_evt(FN_EDGE, 16'h1000);
		settle();

		// Zero attempts counts as one, a timeout of 1 ms and slowest timer.
		evt_idle_on = 1'b1;
		res_idle_on = 1'b1;
		set_config(7'd0, 16'd1, 26'd1);
		// Timeout in the first wait, then in the second wait, then a tick that
		// stays within the limit.
		push_evt(FN_START, 16'h0000);
		push_evt(FN_TICK, 16'h0000);
		push_evt(FN_TICK, 16'h0000);
		push_evt(FN_START, 16'h0000);
		push_evt(FN_EDGE, 16'h00FF);
		push_evt(FN_TICK, 16'h0000);
		push_evt(FN_TICK, 16'h0000);
		push_evt(FN_START, 16'h0000);
		push_evt(FN_EDGE, 16'h0100);
		push_evt(FN_TICK, 16'h0000);
		push_evt(FN_EDGE, 16'h0300);
		settle();

		// A zero timeout fails on the first tick; a zero clock gives a zero reading.
		set_config(7'd2, 16'd0, 26'd0);
		push_evt(FN_START, 16'h0000);
		push_evt(FN_TICK, 16'h0000);
		push_evt(FN_EDGE, 16'h4000);
		push_evt(FN_EDGE, 16'h4321);
		settle();

		// Largest count (clamped to the maximum), longest timeout and fastest timer.
		// All periods of one count give the largest reading the block can form.
		evt_idle_on = 1'b0;
		res_idle_on = 1'b0;
		set_config(7'd127, 16'hFFFF, 26'h3FFFFFF);
		push_evt(FN_START, 16'h0000);
		repeat (MAX_PERIODS) begin
			hz = HZ_W'($urandom);
			push_evt(FN_EDGE, hz[STAMP_W-1:0]);
			if ($urandom_range(0, 7) == 0)
				push_evt(FN_TICK, 16'hFFFF);
			push_evt(FN_EDGE, hz[STAMP_W-1:0] + 1'b1);
		end
		settle();

		// Random phases: each picks its registers and idling, runs a handful of
		// measurements and drains before the next register writes.
		rand_base = evt_total;
		while (evt_total - rand_base < RANDOM_EVENTS) begin
			case ($urandom_range(0, 9))
			0: begin
				nper = 7'd0;
			end
			1: begin
				nper = NUMP_W'($urandom_range(5, 12));
			end
			default: begin
				nper = NUMP_W'($urandom_range(1, 4));
			end
			endcase
			if ($urandom_range(0, 1) == 0)
				tmo = TMO_W'($urandom_range(0, 4));
			else
				tmo = TMO_W'($urandom);
			case ($urandom_range(0, 15))
			0: begin
				hz = '0;
			end
			1: begin
				hz = HZ_W'($urandom_range(1, 1000));
			end
			default: begin
				hz = HZ_W'($urandom);
			end
			endcase
			// Short timeouts get enough ticks to fail some waits; long ones never do.
			tick_max = (tmo <= 4) ? int'(tmo) + 2 : 2;
			attempts = (nper == 0) ? 1 : int'(nper);
			evt_idle_on = ($urandom_range(0, 3) != 0);
			res_idle_on = ($urandom_range(0, 3) != 0);
			set_config(nper, tmo, hz);
			repeat ($urandom_range(3, 8)) push_measurement(attempts, tick_max);
			settle();
		end

		if (err_cnt == 0 && pending_readings.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
